/* rtl/rbd_pkg.sv */
package rbd_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_FACTOR  = 16;
    localparam int NUM_CHAN    = 3;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = COL_W + 1;
    localparam int HEIGHT_W    = 16;
    localparam int FACTOR_W    = $clog2(MAX_FACTOR) + 1;
    localparam int BAND_W      = FACTOR_W - 1;
    localparam int SUM_W       = 16;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int BYTE_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_FACTOR = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_padding;
        logic       row_end;
        logic       last;
    } result_t;

    typedef logic [NUM_CHAN-1:0][SUM_W-1:0] sums_t;

    // Frame geometry derived from the configuration registers.
    typedef struct packed {
        logic                busy;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [FACTOR_W-1:0] factor;
        logic [BAND_W-1:0]   factor_m1;
        logic [RECIP_W-1:0]  recip;
        logic [WIDTH_W-1:0]  ncol;
        logic [WIDTH_W-1:0]  ncol_span;
        logic [HEIGHT_W-1:0] nrow_whole;
    } geom_t;

    typedef struct packed {
        logic load;
        logic update;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic block_done;
        logic final_byte;
        logic slot_free;
    } dp_status_t;

    // ceil(2^24 / (f*f)); exact floor division for sums below 2^16.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [FACTOR_W-1:0] f);
        logic [RECIP_W-1:0] r;
        case (f)
            5'd1:    r = 25'd16777216;
            5'd2:    r = 25'd4194304;
            5'd3:    r = 25'd1864136;
            5'd4:    r = 25'd1048576;
            5'd5:    r = 25'd671089;
            5'd6:    r = 25'd466034;
            5'd7:    r = 25'd342393;
            5'd8:    r = 25'd262144;
            5'd9:    r = 25'd207127;
            5'd10:   r = 25'd167773;
            5'd11:   r = 25'd138655;
            5'd12:   r = 25'd116509;
            5'd13:   r = 25'd99274;
            5'd14:   r = 25'd85599;
            5'd15:   r = 25'd74566;
            5'd16:   r = 25'd65536;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

/* rtl/rbd_cfg.sv */
module rbd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output rbd_pkg::geom_t                      geom
);

    localparam logic [1:0] CS_IDLE = 2'd0;
    localparam logic [1:0] CS_LOAD = 2'd1;
    localparam logic [1:0] CS_DIV  = 2'd2;
    localparam logic [1:0] CS_MUL  = 2'd3;

    localparam int DIV_W = rbd_pkg::HEIGHT_W;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int REM_W = rbd_pkg::FACTOR_W - 1;
    localparam int PROD_W = DIV_W + rbd_pkg::FACTOR_W;

    logic [rbd_pkg::WIDTH_W-1:0]  in_width_reg, in_width_next;
    logic [rbd_pkg::HEIGHT_W-1:0] in_height_reg, in_height_next;
    logic [rbd_pkg::FACTOR_W-1:0] sub_factor_reg, sub_factor_next;

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] dq_w_reg, dq_w_next;
    logic [DIV_W-1:0] dq_h_reg, dq_h_next;
    logic [REM_W-1:0] rem_w_reg, rem_w_next;
    logic [REM_W-1:0] rem_h_reg, rem_h_next;

    logic [rbd_pkg::WIDTH_W-1:0]  ncol_reg, ncol_next;
    logic [rbd_pkg::WIDTH_W-1:0]  ncol_span_reg, ncol_span_next;
    logic [rbd_pkg::HEIGHT_W-1:0] nrow_whole_reg, nrow_whole_next;

    logic [rbd_pkg::WIDTH_W-1:0]  w_eff;
    logic [rbd_pkg::HEIGHT_W-1:0] h_eff;
    logic [rbd_pkg::FACTOR_W-1:0] f_eff;
    logic [REM_W:0]               shift_w, shift_h;
    logic [PROD_W-1:0]            prod_w, prod_h;
    logic                         known_index;

    always_comb
    begin
        if (in_width_reg == '0)
            w_eff = rbd_pkg::WIDTH_W'(1);
        else if (in_width_reg > rbd_pkg::WIDTH_W'(rbd_pkg::MAX_WIDTH))
            w_eff = rbd_pkg::WIDTH_W'(rbd_pkg::MAX_WIDTH);
        else
            w_eff = in_width_reg;

        h_eff = (in_height_reg == '0) ? rbd_pkg::HEIGHT_W'(1) : in_height_reg;

        if (sub_factor_reg == '0)
            f_eff = rbd_pkg::FACTOR_W'(1);
        else if (sub_factor_reg > rbd_pkg::FACTOR_W'(rbd_pkg::MAX_FACTOR))
            f_eff = rbd_pkg::FACTOR_W'(rbd_pkg::MAX_FACTOR);
        else
            f_eff = sub_factor_reg;
    end

    assign known_index = (cfg_index == rbd_pkg::REG_IN_WIDTH) ||
                         (cfg_index == rbd_pkg::REG_IN_HEIGHT) ||
                         (cfg_index == rbd_pkg::REG_SUB_FACTOR);

    assign shift_w = {rem_w_reg, dq_w_reg[DIV_W-1]};
    assign shift_h = {rem_h_reg, dq_h_reg[DIV_W-1]};
    assign prod_w  = {{rbd_pkg::FACTOR_W{1'b0}}, dq_w_reg} *
                     {{DIV_W{1'b0}}, f_eff};
    assign prod_h  = {{rbd_pkg::FACTOR_W{1'b0}}, dq_h_reg} *
                     {{DIV_W{1'b0}}, f_eff};

    always_comb
    begin
        in_width_next   = in_width_reg;
        in_height_next  = in_height_reg;
        sub_factor_next = sub_factor_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        dq_w_next       = dq_w_reg;
        dq_h_next       = dq_h_reg;
        rem_w_next      = rem_w_reg;
        rem_h_next      = rem_h_reg;
        ncol_next       = ncol_reg;
        ncol_span_next  = ncol_span_reg;
        nrow_whole_next = nrow_whole_reg;

        case (phase_reg)
            CS_IDLE:
            begin
            end
            CS_LOAD:
            begin
                dq_w_next  = DIV_W'(w_eff);
                dq_h_next  = h_eff;
                rem_w_next = '0;
                rem_h_next = '0;
                cnt_next   = '1;
                phase_next = CS_DIV;
            end
            CS_DIV:
            begin
                // One restoring step per cycle for both quotients.
                if (shift_w >= f_eff)
                begin
                    rem_w_next = REM_W'(shift_w - f_eff);
                    dq_w_next  = {dq_w_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_w_next = shift_w[REM_W-1:0];
                    dq_w_next  = {dq_w_reg[DIV_W-2:0], 1'b0};
                end
                if (shift_h >= f_eff)
                begin
                    rem_h_next = REM_W'(shift_h - f_eff);
                    dq_h_next  = {dq_h_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_h_next = shift_h[REM_W-1:0];
                    dq_h_next  = {dq_h_reg[DIV_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    phase_next = CS_MUL;
            end
            CS_MUL:
            begin
                ncol_next       = dq_w_reg[rbd_pkg::WIDTH_W-1:0];
                ncol_span_next  = prod_w[rbd_pkg::WIDTH_W-1:0];
                nrow_whole_next = prod_h[rbd_pkg::HEIGHT_W-1:0];
                phase_next      = CS_IDLE;
            end
            default:
            begin
                phase_next = CS_IDLE;
            end
        endcase

        if (cfg_we && known_index)
        begin
            case (cfg_index)
                rbd_pkg::REG_IN_WIDTH:
                    in_width_next = cfg_data[rbd_pkg::WIDTH_W-1:0];
                rbd_pkg::REG_IN_HEIGHT:
                    in_height_next = cfg_data[rbd_pkg::HEIGHT_W-1:0];
                rbd_pkg::REG_SUB_FACTOR:
                    sub_factor_next = cfg_data[rbd_pkg::FACTOR_W-1:0];
                default:
                begin
                end
            endcase
            phase_next = CS_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= rbd_pkg::WIDTH_W'(1);
            in_height_reg  <= rbd_pkg::HEIGHT_W'(1);
            sub_factor_reg <= rbd_pkg::FACTOR_W'(1);
            phase_reg      <= CS_IDLE;
            cnt_reg        <= '0;
            ncol_reg       <= rbd_pkg::WIDTH_W'(1);
            ncol_span_reg  <= rbd_pkg::WIDTH_W'(1);
            nrow_whole_reg <= rbd_pkg::HEIGHT_W'(1);
        end
        else
        begin
            in_width_reg   <= in_width_next;
            in_height_reg  <= in_height_next;
            sub_factor_reg <= sub_factor_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            ncol_reg       <= ncol_next;
            ncol_span_reg  <= ncol_span_next;
            nrow_whole_reg <= nrow_whole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_w_reg  <= dq_w_next;
        dq_h_reg  <= dq_h_next;
        rem_w_reg <= rem_w_next;
        rem_h_reg <= rem_h_next;
    end

    always_comb
    begin
        geom.busy       = (phase_reg != CS_IDLE);
        geom.width      = w_eff;
        geom.height     = h_eff;
        geom.factor     = f_eff;
        geom.factor_m1  = rbd_pkg::BAND_W'(f_eff - rbd_pkg::FACTOR_W'(1));
        geom.recip      = rbd_pkg::recip_of(f_eff);
        geom.ncol       = ncol_reg;
        geom.ncol_span  = ncol_span_reg;
        geom.nrow_whole = nrow_whole_reg;
    end

endmodule

/* rtl/rbd_ctrl.sv */
module rbd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    input  rbd_pkg::geom_t      geom,
    input  rbd_pkg::dp_status_t status,
    output logic                pixel_ready,
    output rbd_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;

    assign pixel_ready = (state_reg == ST_IDLE) && !geom.busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid && pixel_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.update = 1'b1;
                state_next = status.block_done ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.final_byte)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/rbd_datapath.sv */
module rbd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  rbd_pkg::pixel_t     pixel,
    input  rbd_pkg::geom_t      geom,
    input  rbd_pkg::ctrl_cmd_t  cmd,
    input  logic                result_ready,
    output logic                result_valid,
    output rbd_pkg::result_t    result,
    output rbd_pkg::dp_status_t status
);

    localparam int PROD_W = rbd_pkg::SUM_W + rbd_pkg::RECIP_W;
    localparam int IDX_W  = rbd_pkg::BYTE_IDX_W;

    logic [rbd_pkg::SUM_W*rbd_pkg::NUM_CHAN-1:0] sum_mem [rbd_pkg::MAX_WIDTH];
    rbd_pkg::sums_t rd_data_reg;
    rbd_pkg::sums_t sum_reg, sum_next;
    rbd_pkg::pixel_t pix_reg;

    logic [rbd_pkg::COL_W-1:0]    cp_reg, cp_next;
    logic [rbd_pkg::HEIGHT_W-1:0] rp_reg, rp_next;
    logic [rbd_pkg::BAND_W-1:0]   rib_reg, rib_next;
    logic [rbd_pkg::BAND_W-1:0]   cib_reg, cib_next;
    logic [rbd_pkg::COL_W-1:0]    oc_reg, oc_next;

    logic             row_last_reg, row_last_next;
    logic [IDX_W-1:0] nres_m1_reg, nres_m1_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             rvalid_reg, rvalid_next;
    rbd_pkg::result_t result_reg, result_next;

    logic [rbd_pkg::FACTOR_W-1:0] cib_inc, rib_inc;
    logic [rbd_pkg::WIDTH_W-1:0]  cp_inc;
    logic [rbd_pkg::HEIGHT_W:0]   rp_inc;
    logic                         fresh, block_done, final_byte;
    logic [7:0]                   px [rbd_pkg::NUM_CHAN];
    logic [rbd_pkg::SUM_W-1:0]    sel_sum;
    logic [PROD_W-1:0]            prod;

    // Byte order on the output follows the input: red, green, blue.
    assign px[0] = pix_reg.red;
    assign px[1] = pix_reg.green;
    assign px[2] = pix_reg.blue;

    assign fresh = (cib_reg == '0) && (rib_reg == '0);

    always_comb
    begin
        for (int c = 0; c < rbd_pkg::NUM_CHAN; c++)
        begin
            if (fresh)
                sum_next[c] = {{(rbd_pkg::SUM_W-8){1'b0}}, px[c]};
            else
                sum_next[c] = rd_data_reg[c] + {{(rbd_pkg::SUM_W-8){1'b0}}, px[c]};
        end
    end

    assign block_done = (cib_reg == geom.factor_m1) && (rib_reg == geom.factor_m1) &&
                        ({1'b0, cp_reg} < geom.ncol_span) &&
                        (rp_reg < geom.nrow_whole) &&
                        ({1'b0, oc_reg} < geom.ncol);

    assign cib_inc = {1'b0, cib_reg} + rbd_pkg::FACTOR_W'(1);
    assign rib_inc = {1'b0, rib_reg} + rbd_pkg::FACTOR_W'(1);
    assign cp_inc  = {1'b0, cp_reg} + rbd_pkg::WIDTH_W'(1);
    assign rp_inc  = {1'b0, rp_reg} + (rbd_pkg::HEIGHT_W+1)'(1);

    always_comb
    begin
        cp_next  = cp_reg;
        rp_next  = rp_reg;
        rib_next = rib_reg;
        cib_next = cib_reg;
        oc_next  = oc_reg;
        if (cmd.update)
        begin
            if (cib_inc >= geom.factor)
            begin
                cib_next = '0;
                oc_next  = oc_reg + rbd_pkg::COL_W'(1);
            end
            else
            begin
                cib_next = cib_inc[rbd_pkg::BAND_W-1:0];
            end
            cp_next = cp_inc[rbd_pkg::COL_W-1:0];
            if (cp_inc >= geom.width)
            begin
                cp_next  = '0;
                cib_next = '0;
                oc_next  = '0;
                rib_next = (rib_inc >= geom.factor) ? '0 : rib_inc[rbd_pkg::BAND_W-1:0];
                if (rp_inc >= {1'b0, geom.height})
                begin
                    rp_next  = '0;
                    rib_next = '0;
                end
                else
                begin
                    rp_next = rp_inc[rbd_pkg::HEIGHT_W-1:0];
                end
            end
        end
    end

    // Pad bytes per row are (4 - 3*ncol mod 4) mod 4, which is ncol mod 4.
    always_comb
    begin
        row_last_next = row_last_reg;
        nres_m1_next  = nres_m1_reg;
        if (cmd.update)
        begin
            row_last_next = ({1'b0, oc_reg} == geom.ncol - rbd_pkg::WIDTH_W'(1));
            if (row_last_next)
                nres_m1_next = IDX_W'(2) + {1'b0, geom.ncol[1:0]};
            else
                nres_m1_next = IDX_W'(2);
        end
    end

    assign final_byte = (idx_reg == nres_m1_reg);

    always_comb
    begin
        case (idx_reg)
            3'd0:    sel_sum = sum_reg[0];
            3'd1:    sel_sum = sum_reg[1];
            default: sel_sum = sum_reg[2];
        endcase
    end

    assign prod = {{rbd_pkg::RECIP_W{1'b0}}, sel_sum} *
                  {{rbd_pkg::SUM_W{1'b0}}, geom.recip};

    always_comb
    begin
        idx_next    = idx_reg;
        result_next = result_reg;
        rvalid_next = rvalid_reg;
        if (cmd.update)
            idx_next = '0;
        if (cmd.emit)
        begin
            idx_next               = idx_reg + IDX_W'(1);
            result_next.is_padding = (idx_reg >= IDX_W'(rbd_pkg::NUM_CHAN));
            result_next.out_byte   = result_next.is_padding ? 8'd0
                                                            : prod[rbd_pkg::RECIP_SHIFT +: 8];
            result_next.last       = final_byte;
            result_next.row_end    = final_byte && row_last_reg;
            rvalid_next            = 1'b1;
        end
        else if (result_ready)
        begin
            rvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            rd_data_reg <= sum_mem[oc_reg];
        if (cmd.update)
            sum_mem[oc_reg] <= sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pix_reg <= pixel;
        if (cmd.update)
            sum_reg <= sum_next;
        result_reg   <= result_next;
        row_last_reg <= row_last_next;
        nres_m1_reg  <= nres_m1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg     <= '0;
            rp_reg     <= '0;
            rib_reg    <= '0;
            cib_reg    <= '0;
            oc_reg     <= '0;
            idx_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            cp_reg     <= cp_next;
            rp_reg     <= rp_next;
            rib_reg    <= rib_next;
            cib_reg    <= cib_next;
            oc_reg     <= oc_next;
            idx_reg    <= idx_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign result_valid      = rvalid_reg;
    assign result            = result_reg;
    assign status.block_done = block_done;
    assign status.final_byte = final_byte;
    assign status.slot_free  = !rvalid_reg || result_ready;

endmodule

/* rtl/rgb_box_downsampler_unit.sv */
// A pixel is loaded, then summed into its column (ST_SUM); a pixel that completes a block
// then emits its result bytes (3 to 6) one at a time from ST_EMIT, each registered and
// held until the sink is ready. The next pixel is taken only after the last byte.
// A configuration write starts a geometry update (bit-serial division of
// width and height by the factor), during which no pixel is taken.
// Reset is asynchronous and active low; the column-sum memory is not cleared.
module rgb_box_downsampler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  rbd_pkg::pixel_t                pixel,
    output logic                           result_valid,
    input  logic                           result_ready,
    output rbd_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data
);

    rbd_pkg::geom_t      geom;
    rbd_pkg::ctrl_cmd_t  cmd;
    rbd_pkg::dp_status_t status;

    rbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    rbd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .geom        (geom),
        .status      (status),
        .pixel_ready (pixel_ready),
        .cmd         (cmd)
    );

    rbd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .geom         (geom),
        .cmd          (cmd),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .status       (status)
    );

`ifndef SYNTHESIS
    // Only one pixel is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("pixel taken while previous pixel still in flight");

    // Geometry must be settled before a pixel is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        geom.busy |-> !pixel_ready)
        else $error("pixel ready during geometry update");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_padding |-> result.out_byte == 8'd0)
        else $error("pad byte is not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.row_end |-> result.last)
        else $error("row end on a byte that is not the last of its pixel");
`endif

endmodule

/* tb/tb.sv */
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rbd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;

    // Box-average predictor and the queue of result beats it expects.
    class downsample_checker;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned factor_reg;
        int unsigned col_sum [MAX_WIDTH][NUM_CHAN];
        int unsigned column_pos;
        int unsigned row_pos;
        int unsigned row_in_band;
        int unsigned col_in_block;
        int unsigned out_column;
        result_t     pending_bytes[$];
        int unsigned mismatches;
        int unsigned pixel_count;
        int unsigned byte_count;

        function new();
            width_reg    = 1;
            height_reg   = 1;
            factor_reg   = 1;
            column_pos   = 0;
            row_pos      = 0;
            row_in_band  = 0;
            col_in_block = 0;
            out_column   = 0;
            mismatches   = 0;
            pixel_count  = 0;
            byte_count   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_IN_WIDTH:   width_reg = val[WIDTH_W-1:0];
                REG_IN_HEIGHT:  height_reg = val[HEIGHT_W-1:0];
                REG_SUB_FACTOR: factor_reg = val[FACTOR_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int unsigned eff_factor();
            if (factor_reg == 0)
                return 1;
            return (factor_reg > MAX_FACTOR) ? MAX_FACTOR : factor_reg;
        endfunction

        // Small frames end at the frame start, tall ones at the next band start.
        function bit phase_done();
            return column_pos == 0 && row_in_band == 0 && (row_pos == 0 || eff_height() > 64);
        endfunction

        function void take_pixel(pixel_t p);
            int unsigned w;
            int unsigned h;
            int unsigned f;
            int unsigned ncol;
            int unsigned nrow_whole;
            int unsigned area;
            int unsigned pad;
            int unsigned chan [NUM_CHAN];
            bit          fresh;
            bit          row_last;
            result_t     r;

            w = eff_width();
            h = eff_height();
            f = eff_factor();
            ncol = w / f;
            nrow_whole = (h / f) * f;
            chan[0] = p.red;
            chan[1] = p.green;
            chan[2] = p.blue;
            pixel_count++;

            if (out_column < MAX_WIDTH) begin
                fresh = (col_in_block == 0) && (row_in_band == 0);
                for (int c = 0; c < NUM_CHAN; c++)
                    col_sum[out_column][c] = fresh ? chan[c] : col_sum[out_column][c] + chan[c];

                if (col_in_block == f - 1 && row_in_band == f - 1 && column_pos < ncol * f &&
                    row_pos < nrow_whole && out_column < ncol) begin
                    area = f * f;
                    row_last = (out_column == ncol - 1);
                    pad = row_last ? (4 - (3 * ncol) % 4) % 4 : 0;
                    for (int c = 0; c < NUM_CHAN; c++) begin
                        r.out_byte   = 8'(col_sum[out_column][c] / area);
                        r.is_padding = 1'b0;
                        r.row_end    = row_last && pad == 0 && c == NUM_CHAN - 1;
                        r.last       = pad == 0 && c == NUM_CHAN - 1;
                        pending_bytes.push_back(r);
                    end
                    for (int i = 0; i < pad; i++) begin
                        r.out_byte   = 8'h00;
                        r.is_padding = 1'b1;
                        r.row_end    = (i == pad - 1);
                        r.last       = (i == pad - 1);
                        pending_bytes.push_back(r);
                    end
                end
            end

            col_in_block++;
            if (col_in_block >= f) begin
                col_in_block = 0;
                out_column++;
            end
            column_pos++;
            if (column_pos >= w) begin
                column_pos = 0;
                col_in_block = 0;
                out_column = 0;
                row_in_band++;
                if (row_in_band >= f)
                    row_in_band = 0;
                row_pos++;
                if (row_pos >= h) begin
                    row_pos = 0;
                    row_in_band = 0;
                end
            end
        endfunction

        function void check_byte(result_t got);
            result_t want;

            byte_count++;
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat: byte %02h pad %0b end %0b last %0b",
                             $time, got.out_byte, got.is_padding, got.row_end, got.last);
                return;
            end
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.is_padding !== want.is_padding ||
                got.row_end !== want.row_end || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected byte %02h pad %0b end %0b last %0b, got byte %02h pad %0b end %0b last %0b",
                             $time, want.out_byte, want.is_padding, want.row_end, want.last,
                             got.out_byte, got.is_padding, got.row_end, got.last);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_ready;
    pixel_t                pixel;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    downsample_checker sb = new();

    rgb_box_downsampler_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("** rgb_box_downsampler_unit: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_byte(result);
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Extreme channel values show up more often than a flat spread would give.
    function automatic logic [7:0] random_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;

        p.red   = random_byte();
        p.green = random_byte();
        p.blue  = random_byte();
        return p;
    endfunction

    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        sb.take_pixel(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // A pixel that finishes no block leaves nothing to wait for, so allow the
    // pipeline and any geometry update time to finish after the last beat.
    task automatic settle();
        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] f, input int n);
        settle();
        write_reg(REG_IN_WIDTH, w);
        write_reg(REG_IN_HEIGHT, h);
        write_reg(REG_SUB_FACTOR, f);
        cfg_we <= 1'b0;
        for (int k = 0; k < n; k++)
            send_pixel(random_pixel());
        while (!sb.phase_done())
            send_pixel(random_pixel());
        pixel_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel = '0;
        result_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IN_WIDTH;
        cfg_data = '0;
        send_idle_pct = 27;
        recv_idle_pct = 56;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry is one pixel per frame: every beat is a block plus one pad byte.
        send_pixel('{8'h00, 8'h00, 8'h00});
        send_pixel('{8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'hA5, 8'h5A, 8'hC3});
        send_pixel('{8'h5A, 8'hA5, 8'h3C});
        pixel_valid <= 1'b0;

        settle();
        write_reg(REG_IN_WIDTH, 16'd2);
        write_reg(REG_IN_HEIGHT, 16'd2);
        write_reg(REG_SUB_FACTOR, 16'd2);
        write_reg(REG_UNUSED, 16'd5);
        cfg_we <= 1'b0;
        repeat (4) send_pixel('{8'hFF, 8'hFF, 8'hFF});
        // Averages that have to be floored.
        send_pixel('{8'h03, 8'h00, 8'hFF});
        send_pixel('{8'h00, 8'h00, 8'hFF});
        send_pixel('{8'h00, 8'h01, 8'hFF});
        send_pixel('{8'h00, 8'h00, 8'hFE});
        pixel_valid <= 1'b0;

        run_phase(16'd0, 16'd0, 16'd0, $urandom_range(8, 16));
        run_phase(16'd5, 16'd7, 16'd2, $urandom_range(8, 16));
        run_phase(16'd9, 16'd9, 16'd3, $urandom_range(8, 16));
        run_phase(16'd12, 16'd4, 16'd3, $urandom_range(8, 16));

        send_idle_pct = 56;
        recv_idle_pct = 27;
        run_phase(16'd3, 16'd2, 16'd4, $urandom_range(8, 16));
        run_phase(16'd17, 16'hFFFF, 16'd31, $urandom_range(8, 16));
        // The height shrinks below the current row here, so the frame wraps early.
        run_phase(16'd13, 16'd4, 16'd3, $urandom_range(8, 16));
        run_phase(16'd6, 16'd5, 16'd5, $urandom_range(8, 16));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(16'd4096, 16'd1, 16'd1, $urandom_range(8, 16));
        run_phase(16'hFFFF, 16'd0, 16'd1, $urandom_range(8, 16));
        run_phase(16'd16, 16'd16, 16'hFFF0, $urandom_range(8, 16));

        settle();
        $display("Run covered %0d pixel beats and %0d result beats over eleven geometries.",
                 sb.pixel_count, sb.byte_count);
        $display("Mismatched or unexpected result beats: %0d.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
            $display("** rgb_box_downsampler_unit: PASSED **");
        else
            $display("** rgb_box_downsampler_unit: FAILED **");
        $finish;
    end

endmodule
